>>> hw/rtl/opportunistic_rb_scheduler_top_defines.svh
// Assertion macros used by the scheduler datapath.
`ifndef OPPORTUNISTIC_RB_SCHEDULER_TOP_DEFINES_SVH
`define OPPORTUNISTIC_RB_SCHEDULER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication or plain property.
`define OPRB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent this cycle, consequent next cycle.
`define OPRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OPRB_ASSERT(lbl, clk, rst_n, prop, msg)
`define OPRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> hw/rtl/oprb_pkg.sv
// Types, codes and the CQI byte table of the RB scheduler.
package oprb_pkg;

    localparam int USERS_DEF       = 16;
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int MAX_REPORTS     = 16;
    localparam int RPT_CW          = 5;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FINITE = 2'd0,
        CFG_QCAP   = 2'd1,
        CFG_ACTIVE = 2'd2,
        CFG_FRAME  = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        KIND_ACCEPT    = 3'd0,
        KIND_DROP_FULL = 3'd1,
        KIND_DROP_OVF  = 3'd2,
        KIND_USER      = 3'd3,
        KIND_TOTAL     = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ARRIVE,
        ST_REPORT,
        ST_CHECK,
        ST_SCAN,
        ST_SRV_CHK,
        ST_RD,
        ST_LOAD,
        ST_EVAL,
        ST_EMIT_USER,
        ST_NEXT,
        ST_EMIT_TOTAL
    } t_state;

    typedef struct packed {
        logic load_item;
        logic arr_commit;
        logic rep_store;
        logic frame_start;
        logic serve_start;
        logic load_size;
        logic eval_step;
        logic emit_user;
        logic next_entry;
        logic next_cqi;
        logic emit_total;
    } t_cmd;

    typedef struct packed {
        logic is_report;
        logic frame_ready;
        logic entry_match;
        logic entry_last;
        logic cqi_zero;
        logic q_none;
        logic ev_stop;
        logic ev_split;
        logic pop_last;
        logic out_free;
    } t_status;

    function automatic logic [6:0] rb_bytes(input logic [3:0] cqi);
        logic [6:0] b;
        unique case (cqi)
            4'd0:    b = 7'd0;
            4'd1:    b = 7'd3;
            4'd2:    b = 7'd3;
            4'd3:    b = 7'd6;
            4'd4:    b = 7'd11;
            4'd5:    b = 7'd15;
            4'd6:    b = 7'd20;
            4'd7:    b = 7'd25;
            4'd8:    b = 7'd36;
            4'd9:    b = 7'd39;
            4'd10:   b = 7'd50;
            4'd11:   b = 7'd63;
            4'd12:   b = 7'd72;
            4'd13:   b = 7'd80;
            default: b = 7'd93;
        endcase
        return b;
    endfunction

endpackage

>>> hw/rtl/oprb_ctrl.sv
// Controller state machine of the RB scheduler.
module oprb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  oprb_pkg::t_status i_status,
    output oprb_pkg::t_cmd    o_cmd
);
    import oprb_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = (r_state == ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                n_state = i_status.is_report ? ST_REPORT : ST_ARRIVE;
            end
            ST_ARRIVE: begin
                if (i_status.out_free) begin
                    o_cmd.arr_commit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_REPORT: begin
                o_cmd.rep_store = 1'b1;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_status.frame_ready) begin
                    o_cmd.frame_start = 1'b1;
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN, ST_NEXT: begin
                if (r_state == ST_SCAN && i_status.entry_match) begin
                    o_cmd.serve_start = 1'b1;
                    n_state = ST_SRV_CHK;
                end else if (i_status.entry_last) begin
                    if (i_status.cqi_zero) begin
                        n_state = ST_EMIT_TOTAL;
                    end else begin
                        o_cmd.next_cqi = 1'b1;
                        n_state = ST_SCAN;
                    end
                end else begin
                    o_cmd.next_entry = 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_SRV_CHK: begin
                n_state = i_status.q_none ? ST_EMIT_USER : ST_LOAD;
            end
            ST_RD: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.load_size = 1'b1;
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                o_cmd.eval_step = 1'b1;
                if (i_status.ev_stop) begin
                    n_state = ST_EMIT_USER;
                end else if (i_status.ev_split) begin
                    n_state = ST_EVAL;
                end else begin
                    n_state = i_status.pop_last ? ST_EMIT_USER : ST_RD;
                end
            end
            ST_EMIT_USER: begin
                if (i_status.out_free) begin
                    o_cmd.emit_user = 1'b1;
                    n_state = ST_NEXT;
                end
            end
            ST_EMIT_TOTAL: begin
                if (i_status.out_free) begin
                    o_cmd.emit_total = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

>>> hw/rtl/oprb_dp.sv
// Datapath of the RB scheduler: queues, packet store, report buffer, tallies, output register.
`include "opportunistic_rb_scheduler_top_defines.svh"
module oprb_dp #(
    parameter int USERS       = oprb_pkg::USERS_DEF,
    parameter int QUEUE_DEPTH = oprb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [oprb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [oprb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_cmd,
    input  logic [23:0]                     i_in_data,
    input  oprb_pkg::t_cmd                  i_cmd,
    output oprb_pkg::t_status               o_status,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [2:0]                      o_out_kind,
    output logic                            o_out_last,
    output logic [71:0]                     o_out_data
);
    import oprb_pkg::*;

    localparam int QN   = (USERS < 16) ? USERS : 16;
    localparam int UIW  = (QN > 1) ? $clog2(QN) : 1;
    localparam int HW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;
    localparam int SD   = QN * QUEUE_DEPTH;
    localparam int AW   = (SD > 1) ? $clog2(SD) : 1;

    // configuration
    logic       r_finite;
    logic [6:0] r_qcap;
    logic [4:0] r_active;
    logic [7:0] r_frame_rbs;

    // captured item
    logic        r_in_cmd;
    logic [3:0]  r_in_user;
    logic [15:0] r_in_size;
    logic [3:0]  r_in_cqi;

    logic [HW-1:0] r_head [QN];
    logic [CW-1:0] r_cnt  [QN];
    logic [15:0]   r_store [SD];
    logic [15:0]   r_rdata;

    logic [7:0]        r_rep_buf [MAX_REPORTS];
    logic [RPT_CW-1:0] r_rep_cnt;
    logic [3:0]        r_scan_i;
    logic [3:0]        r_scan_c;

    // serve state
    logic [3:0]  r_u;
    logic [6:0]  r_b;
    logic [6:0]  r_rem;
    logic [15:0] r_size;
    logic [7:0]  r_remrb;
    logic [15:0] r_ub;
    logic [7:0]  r_ur;
    logic [8:0]  r_up;
    logic [15:0] r_tb;
    logic [7:0]  r_tr;
    logic [7:0]  r_tp;
    logic [31:0] r_lost;

    logic        r_o_valid;
    logic [2:0]  r_o_kind;
    logic        r_o_last;
    logic [3:0]  r_o_user;
    logic [15:0] r_o_bytes;
    logic [7:0]  r_o_rbs;
    logic [7:0]  r_o_pk;
    logic [31:0] r_o_lost;

    logic            out_free;
    logic            in_uvalid, srv_uvalid;
    logic [UIW-1:0]  in_ui, srv_ui;
    logic [CW-1:0]   in_cnt, srv_cnt;
    logic [HW-1:0]   srv_head, head_inc, tail;
    logic [CW:0]     tail_sum;
    t_kind           arr_kind;
    logic [31:0]     lost_inc;
    logic [AW-1:0]   mem_addr;
    logic            mem_we;
    logic [15:0]     mem_wdata;
    logic [4:0]      need;
    logic [7:0]      cur_ent;
    logic [15:0]     cap;
    logic            ev_stop, ev_split, ev_pop;
    logic [6:0]      rem_pop;
    logic [7:0]      up_sat;
    logic [8:0]      tp_sum;

    assign out_free   = !r_o_valid || i_out_ready;
    assign in_uvalid  = ({1'b0, r_in_user} < 5'(QN));
    assign srv_uvalid = ({1'b0, r_u} < 5'(QN));
    assign in_ui      = r_in_user[UIW-1:0];
    assign srv_ui     = r_u[UIW-1:0];
    assign in_cnt     = r_cnt[in_ui];
    assign srv_cnt    = r_cnt[srv_ui];
    assign srv_head   = r_head[srv_ui];
    assign head_inc   = (srv_head == HW'(QUEUE_DEPTH - 1)) ? '0 : srv_head + HW'(1);
    assign tail_sum   = (CW+1)'(r_head[in_ui]) + (CW+1)'(in_cnt);
    assign tail       = (tail_sum >= (CW+1)'(QUEUE_DEPTH))
                        ? HW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : HW'(tail_sum);

    always_comb begin
        if (!in_uvalid) begin
            arr_kind = KIND_DROP_OVF;
        end else if (r_finite && (CMPW'(in_cnt) >= CMPW'(r_qcap))) begin
            arr_kind = KIND_DROP_FULL;
        end else if (in_cnt >= CW'(QUEUE_DEPTH)) begin
            arr_kind = KIND_DROP_OVF;
        end else begin
            arr_kind = KIND_ACCEPT;
        end
    end

    assign lost_inc = (r_lost == '1) ? r_lost : r_lost + 32'd1;

    always_comb begin
        if (i_cmd.arr_commit) begin
            mem_addr = AW'(AW'(in_ui) * AW'(QUEUE_DEPTH) + AW'(tail));
        end else begin
            mem_addr = AW'(AW'(srv_ui) * AW'(QUEUE_DEPTH) + AW'(srv_head));
        end
    end
    assign mem_we    = (i_cmd.arr_commit && arr_kind == KIND_ACCEPT)
                       || (i_cmd.eval_step && ev_split);
    assign mem_wdata = i_cmd.arr_commit ? r_in_size : r_size - 16'(r_rem);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_store[mem_addr];
    end

    // frame threshold: active_users clamped to 1 .. QN
    always_comb begin
        if (r_active == 5'd0) begin
            need = 5'd1;
        end else if (r_active > 5'(QN)) begin
            need = 5'(QN);
        end else begin
            need = r_active;
        end
    end

    assign cur_ent = r_rep_buf[r_scan_i];

    // true remaining capacity: open RB plus untouched RBs
    assign cap      = (r_remrb == 8'd0) ? 16'd0
                      : 16'(r_rem) + 16'(r_b) * 16'(r_remrb - 8'd1);
    assign ev_stop  = r_size > cap;
    assign ev_split = !ev_stop && (16'(r_rem) < r_size);
    assign ev_pop   = !ev_stop && !ev_split;
    assign rem_pop  = r_rem - r_size[6:0];
    assign up_sat   = (r_up > 9'd255) ? 8'd255 : r_up[7:0];
    assign tp_sum   = 9'(r_tp) + 9'(up_sat);

    always_comb begin
        o_status             = '0;
        o_status.is_report   = r_in_cmd;
        o_status.frame_ready = r_rep_cnt >= need;
        o_status.entry_match = cur_ent[3:0] == r_scan_c;
        o_status.entry_last  = (5'(r_scan_i) + 5'd1) == r_rep_cnt;
        o_status.cqi_zero    = r_scan_c == 4'd0;
        o_status.q_none      = !srv_uvalid || srv_cnt == '0;
        o_status.ev_stop     = ev_stop;
        o_status.ev_split    = ev_split;
        o_status.pop_last    = srv_cnt == CW'(1);
        o_status.out_free    = out_free;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_finite    <= 1'b1;
            r_qcap      <= 7'd64;
            r_active    <= 5'd16;
            r_frame_rbs <= 8'd25;
            r_rep_cnt   <= '0;
            r_remrb     <= '0;
            r_lost      <= '0;
            r_o_valid   <= 1'b0;
            for (int q = 0; q < QN; q++) begin
                r_head[q] <= '0;
                r_cnt[q]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_FINITE: r_finite    <= i_cfg_data[0];
                    CFG_QCAP:   r_qcap      <= i_cfg_data[6:0];
                    CFG_ACTIVE: r_active    <= i_cfg_data[4:0];
                    CFG_FRAME:  r_frame_rbs <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_o_valid && i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cmd.arr_commit || i_cmd.emit_user || i_cmd.emit_total) begin
                r_o_valid <= 1'b1;
            end
            if (i_cmd.arr_commit) begin
                if (arr_kind == KIND_ACCEPT) begin
                    r_cnt[in_ui] <= in_cnt + CW'(1);
                end else begin
                    r_lost <= lost_inc;
                end
            end
            if (i_cmd.rep_store) begin
                r_rep_cnt <= (r_rep_cnt < RPT_CW'(MAX_REPORTS)) ? r_rep_cnt + 5'd1 : r_rep_cnt;
            end
            if (i_cmd.frame_start) begin
                r_remrb <= r_frame_rbs;
            end
            if (i_cmd.eval_step) begin
                if (ev_stop) begin
                    if (r_rem < r_b) begin
                        r_remrb <= r_remrb - 8'd1;
                    end
                end else if (ev_split) begin
                    r_remrb <= r_remrb - 8'd1;
                end else begin
                    r_head[srv_ui] <= head_inc;
                    r_cnt[srv_ui]  <= srv_cnt - CW'(1);
                    if (srv_cnt == CW'(1) && rem_pop < r_b) begin
                        r_remrb <= r_remrb - 8'd1;
                    end
                end
            end
            if (i_cmd.emit_total) begin
                r_rep_cnt <= '0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_in_cmd  <= i_in_cmd;
            r_in_user <= i_in_data[3:0];
            r_in_size <= i_in_data[19:4];
            r_in_cqi  <= i_in_data[23:20];
        end
        if (i_cmd.rep_store && r_rep_cnt < RPT_CW'(MAX_REPORTS)) begin
            r_rep_buf[r_rep_cnt[3:0]] <= {r_in_user, r_in_cqi};
        end
        if (i_cmd.frame_start) begin
            r_scan_i <= '0;
            r_scan_c <= 4'd15;
            r_tb     <= '0;
            r_tr     <= '0;
            r_tp     <= '0;
        end
        if (i_cmd.next_entry) begin
            r_scan_i <= r_scan_i + 4'd1;
        end
        if (i_cmd.next_cqi) begin
            r_scan_i <= '0;
            r_scan_c <= r_scan_c - 4'd1;
        end
        if (i_cmd.serve_start) begin
            r_u   <= cur_ent[7:4];
            r_b   <= rb_bytes(cur_ent[3:0]);
            r_rem <= rb_bytes(cur_ent[3:0]);
            r_ub  <= '0;
            r_ur  <= '0;
            r_up  <= '0;
        end
        if (i_cmd.load_size) begin
            r_size <= r_rdata;
        end
        if (i_cmd.eval_step) begin
            if (ev_stop) begin
                if (r_rem < r_b) begin
                    r_ur <= r_ur + 8'd1;
                    r_ub <= r_ub + 16'(r_b - r_rem);
                end
            end else if (ev_split) begin
                r_size <= r_size - 16'(r_rem);
                r_ur   <= r_ur + 8'd1;
                r_ub   <= r_ub + 16'(r_b);
                r_rem  <= r_b;
            end else begin
                r_rem <= rem_pop;
                r_up  <= r_up + 9'd1;
                if (srv_cnt == CW'(1) && rem_pop < r_b) begin
                    r_ur <= r_ur + 8'd1;
                    r_ub <= r_ub + 16'(r_b - rem_pop);
                end
            end
        end
        if (i_cmd.arr_commit) begin
            r_o_kind  <= arr_kind;
            r_o_last  <= 1'b1;
            r_o_user  <= r_in_user;
            r_o_bytes <= '0;
            r_o_rbs   <= '0;
            r_o_pk    <= '0;
            r_o_lost  <= (arr_kind == KIND_ACCEPT) ? r_lost : lost_inc;
        end
        if (i_cmd.emit_user) begin
            r_o_kind  <= KIND_USER;
            r_o_last  <= 1'b0;
            r_o_user  <= r_u;
            r_o_bytes <= r_ub;
            r_o_rbs   <= r_ur;
            r_o_pk    <= up_sat;
            r_o_lost  <= r_lost;
            r_tb      <= r_tb + r_ub;
            r_tr      <= r_tr + r_ur;
            r_tp      <= (tp_sum > 9'd255) ? 8'd255 : tp_sum[7:0];
        end
        if (i_cmd.emit_total) begin
            r_o_kind  <= KIND_TOTAL;
            r_o_last  <= 1'b1;
            r_o_user  <= '0;
            r_o_bytes <= r_tb;
            r_o_rbs   <= r_tr;
            r_o_pk    <= r_tp;
            r_o_lost  <= r_lost;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_kind  = r_o_kind;
    assign o_out_last  = r_o_last;
    assign o_out_data  = {4'd0, r_o_lost, r_o_pk, r_o_rbs, r_o_bytes, r_o_user};

    `OPRB_ASSERT(a_emit_free, i_clk, i_rst_n,
        !(i_cmd.arr_commit || i_cmd.emit_user || i_cmd.emit_total) || out_free,
        "result issued while output register still held")
    `OPRB_ASSERT(a_eval_onehot, i_clk, i_rst_n,
        !i_cmd.eval_step || $onehot({ev_stop, ev_split, ev_pop}),
        "service step outcome not unique")
    `OPRB_ASSERT_NEXT(a_total_clears, i_clk, i_rst_n, i_cmd.emit_total,
        r_rep_cnt == '0 && r_o_last, "frame total did not clear report buffer")

endmodule

>>> hw/rtl/opportunistic_rb_scheduler_top.sv
// Top level of the max-CQI opportunistic resource-block scheduler.
//
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+----------------------------------
//  s_axis   | in        | s_axis_tvalid/tready      | tuser command; tdata user,size,cqi
//  m_axis   | out       | m_axis_tvalid/tready      | tuser kind; tlast; tdata record
//  cfg      | in        | i_cfg_valid/o_cfg_ready   | i_cfg_index, i_cfg_data
//
// One item is worked at a time; s_axis_tready is high only while idle.
// Arrival: capture, dispatch and commit, plus any wait on the output register; a report closing
// no frame: capture, dispatch, store, check. Frame: 16 CQI levels x n buffered reports scanned
// one entry at a time, plus queue check, record and advance per report served, load and evaluate
// per packet, a store read per packet after the first, an evaluate per RB crossed, total record.
// Reset is synchronous, active low; the packet store needs no clearing pass.
// A stalled m_axis holds the result register and the controller waits on it.
module opportunistic_rb_scheduler_top #(
    parameter int USERS       = oprb_pkg::USERS_DEF,
    parameter int QUEUE_DEPTH = oprb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [23:0]                     s_axis_tdata,  // user[3:0] packet_size[19:4] cqi[23:20]
    input  logic                            s_axis_tuser,  // command
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [71:0]                     m_axis_tdata,  // user_id[3:0] bytes_allocated[19:4]
                                                           // rbs_used[27:20] packets_done[35:28]
                                                           // lost_count[67:36]
    output logic [2:0]                      m_axis_tuser,  // kind
    output logic                            m_axis_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [oprb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [oprb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import oprb_pkg::*;

    t_cmd    cmd;
    t_status status;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    oprb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    oprb_dp #(
        .USERS       (USERS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_cmd    (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_kind  (m_axis_tuser),
        .o_out_last  (m_axis_tlast),
        .o_out_data  (m_axis_tdata)
    );

endmodule
